@@ design/gurv_pkg.sv @@
// ----------------------------------------------------------------------------
// gurv_pkg
// Shared widths, function codes and defaults for the reachability block.
// ----------------------------------------------------------------------------
package gurv_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    localparam int VTX_W  = 7;   // vertex numbers and counts
    localparam int FUNC_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [VTX_W-1:0] VCOUNT_RESET = 7'd64;

endpackage

@@ design/gurv_ram.sv @@
// ----------------------------------------------------------------------------
// gurv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gurv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/gurv_ffs.sv @@
// ----------------------------------------------------------------------------
// gurv_ffs
// Find-first-set: index of the lowest set bit of a vertex mask.
// ----------------------------------------------------------------------------
module gurv_ffs #(
    parameter int W = 64
) (
    input  logic [W-1:0]         i_vec,
    output logic                 o_found,
    output logic [$clog2(W)-1:0] o_idx
);

    always_comb begin
        o_idx = '0;
        // scan high to low so the lowest set bit wins
        for (int i = W - 1; i >= 0; i--) begin
            if (i_vec[i]) begin
                o_idx = ($clog2(W))'(i);
            end
        end
    end

    assign o_found = |i_vec;

endmodule

@@ design/graph_unreachable_vertex_finder.sv @@
// ----------------------------------------------------------------------------
// graph_unreachable_vertex_finder
// Directed-graph reachability over an adjacency bit matrix held in RAM.
// ----------------------------------------------------------------------------
// Command-style block: an item is taken when start is high and busy is low.
// An add reads the source row, then writes it back with the new edge bit. A clear
// drops every row's valid bit at once, and an invalid row reads as zero.
// A query reads the start row, then for each reached vertex does one
// adjacency row read through the RAM's single read port followed by the
// merge into the reached set, then sets up the result run, then gives
// one result per cycle. Results appear on the o_ ports for exactly one
// cycle each, marked by o_strobe; they cannot be held off, so the
// receiver must take every beat as it comes. The last beat of a query
// carries o_last_of_run; an empty run is a single beat with o_has_vertex
// low. vertex_count is written through the cfg channel; the user must
// write it only while idle, as the block does not enforce it. Values
// above MAX_VERTICES act as MAX_VERTICES. No clearing pass after reset.
// ----------------------------------------------------------------------------
module graph_unreachable_vertex_finder #(
    parameter int MAX_VERTICES = gurv_pkg::MAX_VERTICES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command channel
    input  logic                        start,
    output logic                        busy,
    input  logic [gurv_pkg::FUNC_W-1:0] i_func,
    input  logic [gurv_pkg::VTX_W-1:0]  i_from_vertex,
    input  logic [gurv_pkg::VTX_W-1:0]  i_to_vertex,
    // configuration write channel (vertex_count)
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gurv_pkg::VTX_W-1:0]  i_cfg_data,
    // result beats
    output logic                        o_strobe,
    output logic [gurv_pkg::VTX_W-1:0]  o_unreachable_count,
    output logic                        o_has_vertex,
    output logic [gurv_pkg::VTX_W-1:0]  o_unreachable_vertex,
    output logic                        o_last_of_run
);

    localparam int MV = MAX_VERTICES;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int VW = gurv_pkg::VTX_W;
    localparam logic [VW-1:0] MAX_V = VW'(MAX_VERTICES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_WR,   // row data back, write row with new edge bit
        ST_Q_START,  // start row back, seed reached and pending sets
        ST_Q_ISSUE,  // pick next pending vertex and read its row, or set up the results
        ST_Q_WAIT,   // row back, merge new vertices
        ST_EMIT      // one result beat per cycle
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [VW-1:0] r_vcount;

    // per-row valid bits: an invalid row reads as all zeros
    logic [MV-1:0] r_row_vld, n_row_vld;
    logic          r_rd_vld;

    // walk state
    logic [MV-1:0] r_vmask,   n_vmask;    // vertices in use
    logic [VW-1:0] r_nused,   n_nused;
    logic [MV-1:0] r_reached, n_reached;
    logic [MV-1:0] r_pending, n_pending;  // reached, row not yet read
    logic [VW-1:0] r_rcnt,    n_rcnt;     // rows read so far; equals |reached| once none is pending
    logic [MV-1:0] r_missing, n_missing;
    logic [VW-1:0] r_count,   n_count;
    logic [VW-1:0] r_remain,  n_remain;
    logic          r_src_ok,  n_src_ok;
    logic [AW-1:0] r_src_idx, n_src_idx;
    logic [AW-1:0] r_dst_idx, n_dst_idx;

    // result registers
    logic          r_strobe, n_strobe;
    logic [VW-1:0] r_ucount, n_ucount;
    logic          r_has,    n_has;
    logic [VW-1:0] r_uvtx,   n_uvtx;
    logic          r_last,   n_last;

    // RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [MV-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [MV-1:0] ram_rdata;
    logic [MV-1:0] row_eff;

    // find-first units
    logic          pend_found;
    logic [AW-1:0] pend_idx;
    logic          miss_found;
    logic [AW-1:0] miss_idx;

    // input decode
    logic          accept;
    logic          src_ok, dst_ok;
    logic [VW-1:0] src_m1, dst_m1;
    logic [VW-1:0] nused_in;
    logic [MV-1:0] vmask_in;
    logic [MV-1:0] fresh;

    gurv_ram #(
        .WIDTH (MV),
        .DEPTH (MV)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    gurv_ffs #(.W(MV)) u_pend_ffs (
        .i_vec   (r_pending),
        .o_found (pend_found),
        .o_idx   (pend_idx)
    );

    gurv_ffs #(.W(MV)) u_miss_ffs (
        .i_vec   (r_missing),
        .o_found (miss_found),
        .o_idx   (miss_idx)
    );

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign src_ok = (i_from_vertex != '0) && (i_from_vertex <= MAX_V);
    assign dst_ok = (i_to_vertex != '0) && (i_to_vertex <= MAX_V);
    assign src_m1 = i_from_vertex - VW'(1);
    assign dst_m1 = i_to_vertex - VW'(1);

    assign nused_in = (r_vcount > MAX_V) ? MAX_V : r_vcount;

    always_comb begin
        for (int i = 0; i < MV; i++) begin
            vmask_in[i] = (VW'(i) < nused_in);
        end
    end

    assign row_eff = r_rd_vld ? ram_rdata : '0;
    // newly reached vertices from the row just read
    assign fresh   = row_eff & r_vmask & ~r_reached;

    always_comb begin
        n_state   = r_state;
        n_row_vld = r_row_vld;
        n_vmask   = r_vmask;
        n_nused   = r_nused;
        n_reached = r_reached;
        n_pending = r_pending;
        n_rcnt    = r_rcnt;
        n_missing = r_missing;
        n_count   = r_count;
        n_remain  = r_remain;
        n_src_ok  = r_src_ok;
        n_src_idx = r_src_idx;
        n_dst_idx = r_dst_idx;
        n_strobe  = 1'b0;
        n_ucount  = r_ucount;
        n_has     = r_has;
        n_uvtx    = r_uvtx;
        n_last    = r_last;

        ram_we    = 1'b0;
        ram_waddr = r_src_idx;
        ram_wdata = row_eff | (MV'(1) << r_dst_idx);
        ram_raddr = src_m1[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                n_src_idx = src_m1[AW-1:0];
                n_dst_idx = dst_m1[AW-1:0];
                n_src_ok  = src_ok;
                if (accept) begin
                    case (i_func)
                        gurv_pkg::FUNC_ADD: begin
                            if (src_ok && dst_ok) begin
                                n_state = ST_ADD_WR;
                            end
                        end
                        gurv_pkg::FUNC_QUERY: begin
                            n_vmask   = vmask_in;
                            n_nused   = nused_in;
                            n_rcnt    = '0;
                            n_state   = ST_Q_START;
                        end
                        gurv_pkg::FUNC_CLEAR: begin
                            n_row_vld = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_ADD_WR: begin
                ram_we               = 1'b1;
                n_row_vld[r_src_idx] = 1'b1;
                n_state              = ST_IDLE;
            end

            ST_Q_START: begin
                n_reached = r_src_ok ? (row_eff & r_vmask) : '0;
                n_pending = r_src_ok ? (row_eff & r_vmask) : '0;
                n_state   = ST_Q_ISSUE;
            end

            ST_Q_ISSUE: begin
                ram_raddr = pend_idx;
                if (pend_found) begin
                    n_pending = r_pending & ~(MV'(1) << pend_idx);
                    n_rcnt    = r_rcnt + VW'(1);
                    n_state   = ST_Q_WAIT;
                end else begin
                    n_missing = r_vmask & ~r_reached;
                    n_count   = r_nused - r_rcnt;
                    n_remain  = r_nused - r_rcnt;
                    n_state   = ST_EMIT;
                end
            end

            ST_Q_WAIT: begin
                n_reached = r_reached | fresh;
                n_pending = r_pending | fresh;
                n_state   = ST_Q_ISSUE;
            end

            ST_EMIT: begin
                n_strobe = 1'b1;
                n_ucount = r_count;
                if (r_remain == '0 || !miss_found) begin
                    // everything reached: one empty beat
                    n_has   = 1'b0;
                    n_uvtx  = '0;
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_has     = 1'b1;
                    n_uvtx    = {{(VW-AW){1'b0}}, miss_idx} + VW'(1);
                    n_last    = (r_remain == VW'(1));
                    n_missing = r_missing & ~(MV'(1) << miss_idx);
                    n_remain  = r_remain - VW'(1);
                    if (r_remain == VW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_vcount  <= gurv_pkg::VCOUNT_RESET;
            r_row_vld <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row_vld <= n_row_vld;
            r_strobe  <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcount <= i_cfg_data;
            end
        end
    end

    // payload and walk registers: no reset needed
    always_ff @(posedge i_clk) begin
        r_rd_vld  <= r_row_vld[ram_raddr];
        r_vmask   <= n_vmask;
        r_nused   <= n_nused;
        r_reached <= n_reached;
        r_pending <= n_pending;
        r_rcnt    <= n_rcnt;
        r_missing <= n_missing;
        r_count   <= n_count;
        r_remain  <= n_remain;
        r_src_ok  <= n_src_ok;
        r_src_idx <= n_src_idx;
        r_dst_idx <= n_dst_idx;
        r_ucount  <= n_ucount;
        r_has     <= n_has;
        r_uvtx    <= n_uvtx;
        r_last    <= n_last;
    end

    assign o_strobe             = r_strobe;
    assign o_unreachable_count  = r_ucount;
    assign o_has_vertex         = r_has;
    assign o_unreachable_vertex = r_uvtx;
    assign o_last_of_run        = r_last;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for graph_unreachable_vertex_finder. Edge, clear and
// query commands go in over start/busy. A behavioral copy of the adjacency
// matrix and vertex_count predicts the unreachable-vertex beats of each query,
// and every o_strobe beat is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int VW   = gurv_pkg::VTX_W;
    localparam int FW   = gurv_pkg::FUNC_W;
    localparam int MAXV = gurv_pkg::MAX_VERTICES_DEF;

    // func code that the block must ignore
    localparam logic [FW-1:0] FUNC_UNUSED = 2'd3;

    // Quiet time before a config write: an add still has its row write to do and emits no beat.
    localparam int CMD_SETTLE = 8;
    // Time to wait for the longest query, with ample margin.
    localparam int QUERY_LATENCY = 3 * MAXV + 20;

    // One result beat as the block should drive it.
    typedef struct packed {
        logic [VW-1:0] count;
        logic          has;
        logic [VW-1:0] vtx;
        logic          last;
    } t_unreach_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [FW-1:0]        i_func = gurv_pkg::FUNC_ADD;
    logic [VW-1:0]        i_from_vertex = '0;
    logic [VW-1:0]        i_to_vertex = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [VW-1:0]        i_cfg_data = '0;
    logic                 o_strobe;
    logic [VW-1:0]        o_unreachable_count;
    logic                 o_has_vertex;
    logic [VW-1:0]        o_unreachable_vertex;
    logic                 o_last_of_run;

    // Predictor state: our own copy of the matrix and of the register.
    logic [63:0]          adj_rows [64];
    logic [VW-1:0]        vtx_count = gurv_pkg::VCOUNT_RESET;
    t_unreach_beat        unreached_beats [$];

    int                   errors = 0;
    int                   burst_left = 0;

    graph_unreachable_vertex_finder dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_func               (i_func),
        .i_from_vertex        (i_from_vertex),
        .i_to_vertex          (i_to_vertex),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_data           (i_cfg_data),
        .o_strobe             (o_strobe),
        .o_unreachable_count  (o_unreachable_count),
        .o_has_vertex         (o_has_vertex),
        .o_unreachable_vertex (o_unreachable_vertex),
        .o_last_of_run        (o_last_of_run)
    );

    always #10 i_clk = ~i_clk;

    // Set of vertices in use that a walk from src does not reach. The start
    // vertex only counts as reached through a path of one or more edges.
    function automatic logic [63:0] unreached_set(input logic [VW-1:0] src);
        int          n;
        int          b;
        logic [63:0] in_use;
        logic [63:0] seen;
        logic [63:0] front;
        logic [63:0] fresh;
        n = (vtx_count > MAXV) ? MAXV : int'(vtx_count);
        in_use = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        seen = '0;
        front = '0;
        if (src >= 1 && src <= MAXV)
            front = adj_rows[src - 1] & in_use;
        // each round adds at least one new vertex, so this terminates
        while (front != '0) begin
            fresh = front & ~seen;
            seen |= fresh;
            front = '0;
            for (b = 0; b < 64; b++)
                if (fresh[b])
                    front |= adj_rows[b] & in_use;
            front &= ~seen;
        end
        return in_use & ~seen;
    endfunction

    // One command beat. Start stays high across back-to-back beats of a
    // burst; a gap drops it for a random number of cycles first. On accept,
    // the predictor is updated and any query beats are queued.
    task automatic send_cmd(input logic [FW-1:0] func,
                            input logic [VW-1:0] src,
                            input logic [VW-1:0] dst);
        int            gap;
        int            k;
        int            b;
        logic [63:0]   missing;
        logic [VW-1:0] total;
        t_unreach_beat beat;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 6);
        end
        if (!start)
            start <= 1'b1;
        i_func <= func;
        i_from_vertex <= src;
        i_to_vertex <= dst;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        burst_left--;

        case (func)
            gurv_pkg::FUNC_ADD: begin
                if (src >= 1 && src <= MAXV &&
                    dst >= 1 && dst <= MAXV)
                    adj_rows[src - 1][dst - 1] = 1'b1;
            end
            gurv_pkg::FUNC_CLEAR: begin
                foreach (adj_rows[r]) adj_rows[r] = '0;
            end
            gurv_pkg::FUNC_QUERY: begin
                missing = unreached_set(src);
                total = VW'($countones(missing));
                if (total == 0) begin
                    // nothing left out: a single empty beat
                    beat = '{count: '0, has: 1'b0, vtx: '0, last: 1'b1};
                    unreached_beats.push_back(beat);
                end else begin
                    k = 0;
                    for (b = 0; b < 64; b++) begin
                        if (missing[b]) begin
                            k++;
                            beat.count = total;
                            beat.has = 1'b1;
                            beat.vtx = VW'(b + 1);
                            beat.last = (k == total);
                            unreached_beats.push_back(beat);
                        end
                    end
                end
            end
            default: ;  // unused func code: no effect
        endcase
    endtask

    // Let the block go idle: all query beats out, then time for a trailing
    // add to finish, then busy low.
    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        while (unreached_beats.size() != 0) @(posedge i_clk);
        repeat (CMD_SETTLE) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_vcount(input logic [VW-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        vtx_count = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result checker. Beats cannot be stalled, so every strobe is taken.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int expv, input int act);
        if (expv != act) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, name, expv, act);
        end
    endtask

    always @(posedge i_clk) begin
        t_unreach_beat want;
        if (i_rst_n && o_strobe) begin
            if (unreached_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none actual vertex %0d",
                         $time, o_unreachable_vertex);
            end else begin
                want = unreached_beats.pop_front();
                check_field("unreachable_count", want.count, o_unreachable_count);
                check_field("has_vertex", want.has, o_has_vertex);
                check_field("unreachable_vertex", want.vtx, o_unreachable_vertex);
                check_field("last_of_run", want.last, o_last_of_run);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Fresh after reset: empty matrix, 64 vertices. Start 0 reaches nothing.
    task automatic test_empty_graph();
        send_cmd(gurv_pkg::FUNC_QUERY, 7'd1, 7'd0);
        send_cmd(gurv_pkg::FUNC_QUERY, 7'd0, 7'd127);
    endtask

    task automatic test_special_cases();
        // 1 -> 2 -> 3 -> 1 cycle: start counts as reached
        send_cmd(gurv_pkg::FUNC_ADD, 7'd1, 7'd2);
        send_cmd(gurv_pkg::FUNC_ADD, 7'd2, 7'd3);
        send_cmd(gurv_pkg::FUNC_ADD, 7'd3, 7'd1);
        // self loop on the top vertex
        send_cmd(gurv_pkg::FUNC_ADD, 7'd64, 7'd64);
        // out-of-range endpoints are dropped
        send_cmd(gurv_pkg::FUNC_ADD, 7'd0, 7'd5);
        send_cmd(gurv_pkg::FUNC_ADD, 7'd5, 7'd0);
        send_cmd(gurv_pkg::FUNC_ADD, 7'd65, 7'd3);
        send_cmd(gurv_pkg::FUNC_ADD, 7'd127, 7'd127);
        // edge into the cycle from a vertex nothing leads to
        send_cmd(gurv_pkg::FUNC_ADD, 7'd4, 7'd1);
        // reserved func is ignored
        send_cmd(FUNC_UNUSED, 7'd127, 7'd127);
        send_cmd(gurv_pkg::FUNC_QUERY, 7'd1, 7'd0);
        send_cmd(gurv_pkg::FUNC_QUERY, 7'd64, 7'd0);
        send_cmd(gurv_pkg::FUNC_QUERY, 7'd4, 7'd0);
        send_cmd(gurv_pkg::FUNC_QUERY, 7'd127, 7'd0);
        send_cmd(gurv_pkg::FUNC_CLEAR, 7'd0, 7'd0);
        send_cmd(gurv_pkg::FUNC_QUERY, 7'd1, 7'd0);
    endtask

    task automatic test_vertex_count();
        write_vcount(7'd2);
        send_cmd(gurv_pkg::FUNC_ADD, 7'd1, 7'd2);
        send_cmd(gurv_pkg::FUNC_ADD, 7'd2, 7'd1);
        // edges touching vertex 40 are stored though 40 is out of use
        send_cmd(gurv_pkg::FUNC_ADD, 7'd1, 7'd40);
        send_cmd(gurv_pkg::FUNC_ADD, 7'd40, 7'd2);
        send_cmd(gurv_pkg::FUNC_QUERY, 7'd1, 7'd0);   // all reached: empty beat
        send_cmd(gurv_pkg::FUNC_QUERY, 7'd40, 7'd0);  // start row read, in-use edges only
        write_vcount(7'd1);
        send_cmd(gurv_pkg::FUNC_QUERY, 7'd1, 7'd0);
        write_vcount(7'd0);                           // no vertices in use
        send_cmd(gurv_pkg::FUNC_QUERY, 7'd1, 7'd0);
        write_vcount(7'd127);                         // saturates to the maximum
        send_cmd(gurv_pkg::FUNC_QUERY, 7'd1, 7'd0);
        write_vcount(7'd64);
        send_cmd(gurv_pkg::FUNC_QUERY, 7'd40, 7'd0);
    endtask

    // Random traffic over several vertex_count settings. Mostly well-formed
    // adds and queries; adds often extend a chain so walks go deep.
    task automatic test_random_traffic();
        logic [VW-1:0] counts [8];
        logic [VW-1:0] tail;
        logic [VW-1:0] src;
        logic [VW-1:0] dst;
        int            hi;
        int            pick;
        counts = '{7'd64, 7'd6, 7'd1, 7'd127, 7'd0, 7'd17, 7'd2, 7'd0};
        counts[7] = VW'($urandom_range(3, 64));
        foreach (counts[p]) begin
            write_vcount(counts[p]);
            hi = (counts[p] > 64) ? 64 : ((counts[p] == 0) ? 1 : int'(counts[p]));
            tail = 7'd1;
            repeat (25) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    src = ($urandom_range(0, 1) == 1) ? tail
                                                      : VW'($urandom_range(1, hi));
                    dst = ($urandom_range(0, 7) == 0) ? VW'($urandom_range(1, 64))
                                                      : VW'($urandom_range(1, hi));
                    tail = dst;
                    send_cmd(gurv_pkg::FUNC_ADD, src, dst);
                end else if (pick < 80) begin
                    src = ($urandom_range(0, 9) == 0) ? VW'($urandom_range(0, 127))
                                                      : VW'($urandom_range(1, hi));
                    send_cmd(gurv_pkg::FUNC_QUERY, src, VW'($urandom_range(0, 127)));
                end else if (pick < 84) begin
                    send_cmd(gurv_pkg::FUNC_CLEAR, VW'($urandom_range(0, 127)),
                             VW'($urandom_range(0, 127)));
                end else begin
                    // noise: any code, any endpoints
                    send_cmd(FW'($urandom_range(0, 3)),
                             VW'($urandom_range(0, 127)),
                             VW'($urandom_range(0, 127)));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        foreach (adj_rows[r]) adj_rows[r] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_graph();
        test_special_cases();
        test_vertex_count();
        test_random_traffic();

        drain();
        repeat (QUERY_LATENCY) @(posedge i_clk);
        if (errors == 0)
            $display("graph_unreachable_vertex_finder test passed");
        else
            $display("graph_unreachable_vertex_finder test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("graph_unreachable_vertex_finder test failed");
        $finish;
    end

endmodule
